### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/dmsr_pkg.sv
package dmsr_pkg;

   localparam int SpeedWidth = 8;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;

   localparam logic [1:0] SEL_LEFT  = 2'd0;
   localparam logic [1:0] SEL_RIGHT = 2'd1;
   localparam logic [1:0] SEL_BOTH  = 2'd2;

   localparam logic [SpeedWidth-1:0] REVERSE_THRESHOLD_RESET = 8'h10;

   // floor(s / 3) == (s * 171) >> 9 for every 8-bit s
   localparam logic [7:0] DIV3_RECIP = 8'd171;
   localparam int         DIV3_SHIFT = 9;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] motor_select;
      logic       cmd_direction;
      logic [7:0] cmd_speed;
   } req_item_type;

   typedef struct packed {
      logic [7:0] pwm_left;
      logic [7:0] pwm_right;
      logic       dir_pin_left;
      logic       dir_pin_right;
   } rsp_item_type;

   // per-motor strobes for one processed item
   typedef struct packed {
      logic tick;
      logic store;
      logic commit;
   } motor_ctl_type;

endpackage

### sv/dmsr_in_stage.sv
module dmsr_in_stage
   import dmsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   // take a new item whenever the held one moves on or the stage is empty
   assign load      = !valid_ff || advance;
   assign req_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### sv/dmsr_motor.sv
module dmsr_motor
   import dmsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  motor_ctl_type         ctl,
   input  logic                  cmd_direction,
   input  logic [SpeedWidth-1:0] cmd_speed,
   input  logic [SpeedWidth-1:0] reverse_threshold,
   output logic [SpeedWidth-1:0] speed,
   output logic                  dir
);

   logic [SpeedWidth-1:0] cur_speed_ff, cur_speed_in;
   logic                  cur_dir_ff, cur_dir_in;
   logic [SpeedWidth-1:0] goal_spd_ff, goal_spd_in;
   logic                  goal_dir_ff, goal_dir_in;
   logic [SpeedWidth-1:0] queued_spd_ff, queued_spd_in;
   logic                  queued_dir_ff, queued_dir_in;

   logic signed [SpeedWidth:0] diff;
   logic signed [SpeedWidth:0] half;
   logic [SpeedWidth-1:0]      approach;
   logic [2*SpeedWidth-1:0]    prod;
   logic [SpeedWidth-1:0]      third;

   // halve the signed gap, rounding toward zero
   assign diff     = $signed({1'b0, goal_spd_ff}) - $signed({1'b0, cur_speed_ff});
   assign half     = (diff + $signed({{SpeedWidth{1'b0}}, diff[SpeedWidth]})) >>> 1;
   assign approach = cur_speed_ff + half[SpeedWidth-1:0];

   assign prod  = cur_speed_ff * DIV3_RECIP;
   assign third = SpeedWidth'(prod >> DIV3_SHIFT);

   always_comb begin
      cur_speed_in  = cur_speed_ff;
      cur_dir_in    = cur_dir_ff;
      goal_spd_in   = goal_spd_ff;
      goal_dir_in   = goal_dir_ff;
      queued_spd_in = queued_spd_ff;
      queued_dir_in = queued_dir_ff;
      if (ctl.tick) begin
         if (cur_dir_ff == goal_dir_ff) begin
            cur_speed_in = approach;
         end else if (cur_speed_ff < reverse_threshold) begin
            cur_dir_in = goal_dir_ff;
         end else begin
            cur_speed_in = cur_speed_ff - third;
         end
      end
      if (ctl.store) begin
         queued_spd_in = cmd_speed;
         queued_dir_in = cmd_direction;
      end
      if (ctl.commit) begin
         goal_spd_in = queued_spd_ff;
         goal_dir_in = queued_dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_speed_ff  <= '0;
         cur_dir_ff    <= 1'b0;
         goal_spd_ff   <= '0;
         goal_dir_ff   <= 1'b0;
         queued_spd_ff <= '0;
         queued_dir_ff <= 1'b0;
      end else begin
         cur_speed_ff  <= cur_speed_in;
         cur_dir_ff    <= cur_dir_in;
         goal_spd_ff   <= goal_spd_in;
         goal_dir_ff   <= goal_dir_in;
         queued_spd_ff <= queued_spd_in;
         queued_dir_ff <= queued_dir_in;
      end
   end

   assign speed = cur_speed_ff;
   assign dir   = cur_dir_ff;

endmodule

### sv/dual_motor_speed_ramp_unit.sv
// A result follows its request transfer through the input register, then the motor state registers.
// Throughput: one item per cycle; the only limit is the single result register under rsp_stall.
// The motor state registers double as the result register, so each result shows state after its item.
// Reset (synchronous, active high) clears both stages, zeroes all speeds, sets all directions
// forward and loads reverse_threshold with 16.
`include "assert_macros.svh"

module dual_motor_speed_ramp_unit
   import dmsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   logic          item_valid;
   req_item_type  item;
   logic          advance;
   logic          process;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    threshold_ff, threshold_in;
   logic          sel_left, sel_right;
   motor_ctl_type ctl_left, ctl_right;
   logic [7:0]    speed_left, speed_right;
   logic          dir_left, dir_right;

   // Advance the pipeline unless a finished result is held by the consumer.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign process = item_valid && advance;

   dmsr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Decode the selector; select three addresses neither motor.
   always_comb begin
      sel_left  = 1'b0;
      sel_right = 1'b0;
      unique case (item.motor_select)
         SEL_LEFT: begin
            sel_left = 1'b1;
         end
         SEL_RIGHT: begin
            sel_right = 1'b1;
         end
         SEL_BOTH: begin
            sel_left  = 1'b1;
            sel_right = 1'b1;
         end
         default: begin
            sel_left  = 1'b0;
            sel_right = 1'b0;
         end
      endcase
   end

   // Build per-motor strobes; a tick always hits both motors, operation three does nothing.
   always_comb begin
      ctl_left  = '0;
      ctl_right = '0;
      if (process) begin
         unique case (item.operation)
            OP_TICK: begin
               ctl_left.tick  = 1'b1;
               ctl_right.tick = 1'b1;
            end
            OP_STORE: begin
               ctl_left.store  = sel_left;
               ctl_right.store = sel_right;
            end
            OP_COMMIT: begin
               ctl_left.commit  = sel_left;
               ctl_right.commit = sel_right;
            end
            default: begin
               ctl_left  = '0;
               ctl_right = '0;
            end
         endcase
      end
   end

   dmsr_motor u_motor_left (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl_left),
      .cmd_direction     (item.cmd_direction),
      .cmd_speed         (item.cmd_speed),
      .reverse_threshold (threshold_ff),
      .speed             (speed_left),
      .dir               (dir_left)
   );

   dmsr_motor u_motor_right (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl_right),
      .cmd_direction     (item.cmd_direction),
      .cmd_speed         (item.cmd_speed),
      .reverse_threshold (threshold_ff),
      .speed             (speed_right),
      .dir               (dir_right)
   );

   // Result valid: load on advance, hold while the transfer is stalled.
   assign rsp_valid_in = advance ? item_valid : rsp_valid_ff;

   // Configuration: always ready; writes must arrive only while idle, which the block itself does not enforce.
   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         threshold_ff <= REVERSE_THRESHOLD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   // The state only changes when the pipeline advances, so it holds under stall.
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_item.pwm_left      = speed_left;
   assign rsp_item.pwm_right     = speed_right;
   assign rsp_item.dir_pin_left  = ~dir_left;
   assign rsp_item.dir_pin_right = dir_right;

   `ASSERT_NEXT(a_proc_gives_rsp, clock, reset, process, rsp_valid)
   `ASSERT_IMPLIES(a_empty_no_stall, clock, reset, !rsp_valid_ff, !req_stall)
   `ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready, threshold_ff == $past(csr_data))
   `ASSERT_NEXT(a_no_proc_state_hold, clock, reset, !process,
                $stable(speed_left) && $stable(speed_right) && $stable(dir_left) && $stable(dir_right))

endmodule
